// ===== design/ott_pkg.sv =====
// shared types and constants of the ordered timer table
package ott_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 48;
  localparam int MAX_RES       = 16;
  localparam int CNT_W         = $clog2(MAX_RES + 1);
  localparam int PERIOD_W      = 32;
  localparam int SLOT_IN_W     = 4;
  localparam int LEFT_W        = 48;
  localparam int IN_DATA_W     = 40;
  localparam int OUT_DATA_W    = 56;
  localparam int OP_W          = 3;

  localparam logic [LEFT_W-1:0] LEFT_ALL = '1;
  localparam logic [LEFT_W-1:0] LEFT_SAT = LEFT_ALL - LEFT_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_REFRESH = 3'd2,
    OP_CHANGE  = 3'd3,
    OP_TICK    = 3'd4,
    OP_QUERY   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_INACTIVE = 2'd2,
    STS_NONE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [LEFT_W-1:0]    left;
    logic                 front;
    logic                 expired;
    logic [SLOT_IN_W-1:0] slot;
    status_e              status;
    logic                 last;
  } res_t;

endpackage

// ===== design/ordered_timer_table_core.sv =====
// ordered timer table: slot memory, minimum search sequencer and result register
// add, query, refresh and change period run a minimum search over all slots; cancel answers without one
// a tick repeats the minimum search for each due timer it reports, at most 16 per tick
// a search is paced by the single read port of the slot memory, read once per slot per search
// one item at a time; the next request is taken once the last result is in the output register
// reset clears the tick count, the active flags and the control state; the memory keeps its data
module ordered_timer_table_core #(
  parameter int SLOTS     = ott_pkg::SLOTS_DEF,
  parameter int TIME_BITS = ott_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // slot, period, recurring, restart, zero fill
  input  logic [ott_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic [ott_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status, result_slot, expired, front_changed, time_left
  output logic [ott_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);
  import ott_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [SLOT_W-1:0]    idx_t;
  typedef logic [TIME_BITS-1:0] tm_t;

  typedef struct packed {
    logic                rec;
    logic [PERIOD_W-1:0] period;
    tm_t                 deadline;
  } ent_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_RD       = 7'b0000010,
    ST_SCAN     = 7'b0000100,
    ST_SCAN_END = 7'b0001000,
    ST_DECIDE   = 7'b0010000,
    ST_FLUSH    = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_e;

  ent_t mem_q [SLOTS];
  ent_t rd_q;
  logic mem_we;
  idx_t mem_wa, mem_ra;
  ent_t mem_wd;

  state_e state_q, state_d, ret_q, ret_d;
  op_e    op_q, op_d;
  idx_t   tgt_q, tgt_d;
  logic [PERIOD_W-1:0] per_q, per_d;
  logic   fnow_q, fnow_d;
  tm_t    now_q, now_d;
  logic [SLOTS-1:0] active_q, active_d, done_q, done_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic   pend_valid_q, pend_valid_d;
  idx_t   pend_q, pend_d;
  logic   best_valid_q, best_valid_d;
  idx_t   best_idx_q, best_idx_d;
  ent_t   best_q, best_d;
  idx_t   scan_q, scan_d;
  logic   rv_q;
  idx_t   ridx_q;
  res_t   res_q, res_d, m_res_q, m_res_d;
  logic   m_valid_q, m_valid_d;

  logic [SLOT_IN_W-1:0] in_slot;
  logic [PERIOD_W-1:0]  in_per;
  logic                 in_rec, in_fnow, in_valid, free_found, due;
  idx_t                 in_idx, free_idx;
  op_e                  in_op;
  logic [63:0]          left64;
  state_e               nxt;

  assign in_slot  = s_axis_tdata[3:0];
  assign in_per   = s_axis_tdata[35:4];
  assign in_rec   = s_axis_tdata[36];
  assign in_fnow  = s_axis_tdata[37];
  assign in_op    = op_e'(s_axis_tuser);
  assign in_idx   = idx_t'(in_slot);
  assign in_valid = (32'(in_slot) < 32'(SLOTS)) && active_q[in_idx];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_res_q.left, m_res_q.front, m_res_q.expired,
                          m_res_q.slot, m_res_q.status};
  assign m_axis_tlast  = m_res_q.last;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = idx_t'(i);
      end
    end
  end

  assign due = best_valid_q && (best_q.deadline <= now_q);
  assign left64 = (64'(best_q.deadline) > 64'(now_q)) ?
                  (64'(best_q.deadline) - 64'(now_q)) : 64'd0;

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    op_d         = op_q;
    tgt_d        = tgt_q;
    per_d        = per_q;
    fnow_d       = fnow_q;
    now_d        = now_q;
    active_d     = active_q;
    done_d       = done_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    best_valid_d = best_valid_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    scan_d       = scan_q;
    res_d        = res_q;
    m_res_d      = m_res_q;
    m_valid_d    = m_valid_q;
    mem_we       = 1'b0;
    mem_wa       = tgt_q;
    mem_wd       = rd_q;
    mem_ra       = scan_q;
    nxt          = ST_SCAN;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // running minimum over the slot memory, ties kept by the lower slot
    if (rv_q && active_q[ridx_q] && !done_q[ridx_q] &&
        (!best_valid_q || (rd_q.deadline < best_q.deadline))) begin
      best_valid_d = 1'b1;
      best_idx_d   = ridx_q;
      best_d       = rd_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        mem_ra = in_idx;
        if (s_axis_tvalid) begin
          op_d         = in_op;
          tgt_d        = in_idx;
          per_d        = in_per;
          fnow_d       = in_fnow;
          done_d       = '0;
          scan_d       = '0;
          best_valid_d = 1'b0;
          res_d        = '0;
          res_d.last   = 1'b1;
          ret_d        = ST_IDLE;
          state_d      = ST_EMIT;
          unique case (in_op)
            OP_ADD: begin
              if (!free_found) begin
                res_d.status = STS_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_wa          = free_idx;
                mem_wd.rec      = in_rec;
                mem_wd.period   = in_per;
                mem_wd.deadline = tm_t'(64'(now_q) + 64'(in_per));
                active_d[free_idx] = 1'b1;
                tgt_d           = free_idx;
                state_d         = ST_SCAN;
              end
            end
            OP_CANCEL: begin
              if (!in_valid) begin
                res_d.status = STS_INACTIVE;
              end else begin
                active_d[in_idx] = 1'b0;
              end
            end
            OP_REFRESH, OP_CHANGE: begin
              if (!in_valid) begin
                res_d.status = STS_INACTIVE;
              end else begin
                state_d = ST_RD;
              end
            end
            OP_TICK: begin
              now_d        = now_q + tm_t'(1);
              n_d          = '0;
              pend_valid_d = 1'b0;
              state_d      = ST_SCAN;
            end
            OP_QUERY: begin
              state_d = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_RD: begin
        mem_we = 1'b1;
        mem_wa = tgt_q;
        mem_wd = rd_q;
        if (op_q == OP_REFRESH || fnow_q) begin
          if (op_q == OP_CHANGE) begin
            mem_wd.period = per_q;
          end
          mem_wd.deadline = tm_t'(64'(now_q) + 64'(mem_wd.period));
        end else begin
          mem_wd.deadline = tm_t'(64'(rd_q.deadline) + 64'(per_q) - 64'(rd_q.period));
          mem_wd.period   = per_q;
        end
        scan_d       = '0;
        best_valid_d = 1'b0;
        state_d      = ST_SCAN;
      end

      ST_SCAN: begin
        mem_ra = scan_q;
        if (scan_q == idx_t'(SLOTS - 1)) begin
          state_d = ST_SCAN_END;
        end else begin
          scan_d = scan_q + idx_t'(1);
        end
      end

      ST_SCAN_END: begin
        state_d = ST_DECIDE;
      end

      ST_DECIDE: begin
        res_d      = '0;
        res_d.last = 1'b1;
        ret_d      = ST_IDLE;
        state_d    = ST_EMIT;
        case (op_q)
          OP_TICK: begin
            if (due) begin
              done_d[best_idx_q] = 1'b1;
              n_d = n_q + CNT_W'(1);
              if (best_q.rec) begin
                mem_we          = 1'b1;
                mem_wa          = best_idx_q;
                mem_wd          = best_q;
                mem_wd.deadline = tm_t'(64'(now_q) + 64'(best_q.period));
              end else begin
                active_d[best_idx_q] = 1'b0;
              end
              pend_d       = best_idx_q;
              pend_valid_d = 1'b1;
              scan_d       = '0;
              best_valid_d = 1'b0;
              nxt = (n_q == CNT_W'(MAX_RES - 1)) ? ST_FLUSH : ST_SCAN;
              if (pend_valid_q) begin
                res_d.slot    = SLOT_IN_W'(pend_q);
                res_d.expired = 1'b1;
                res_d.last    = 1'b0;
                ret_d         = nxt;
              end else begin
                state_d = nxt;
              end
            end else begin
              pend_valid_d = 1'b0;
              if (pend_valid_q) begin
                res_d.slot    = SLOT_IN_W'(pend_q);
                res_d.expired = 1'b1;
              end else begin
                res_d.status = STS_NONE;
              end
            end
          end
          OP_QUERY: begin
            if (!best_valid_q) begin
              res_d.status = STS_NONE;
              res_d.left   = LEFT_ALL;
            end else if (left64 >= 64'(LEFT_ALL)) begin
              res_d.left = LEFT_SAT;
            end else begin
              res_d.left = left64[LEFT_W-1:0];
            end
          end
          default: begin
            res_d.front = best_valid_q && (best_idx_q == tgt_q);
            if (op_q == OP_ADD) begin
              res_d.slot = SLOT_IN_W'(tgt_q);
            end
          end
        endcase
      end

      ST_FLUSH: begin
        res_d         = '0;
        res_d.slot    = SLOT_IN_W'(pend_q);
        res_d.expired = 1'b1;
        res_d.last    = 1'b1;
        pend_valid_d  = 1'b0;
        ret_d         = ST_IDLE;
        state_d       = ST_EMIT;
      end

      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_res_d   = res_q;
          state_d   = ret_q;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ret_q        <= ST_IDLE;
      now_q        <= '0;
      active_q     <= '0;
      done_q       <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      best_valid_q <= 1'b0;
      scan_q       <= '0;
      rv_q         <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      now_q        <= now_d;
      active_q     <= active_d;
      done_q       <= done_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      best_valid_q <= best_valid_d;
      scan_q       <= scan_d;
      rv_q         <= (state_q == ST_SCAN);
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    tgt_q      <= tgt_d;
    per_q      <= per_d;
    fnow_q     <= fnow_d;
    pend_q     <= pend_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    ridx_q     <= scan_q;
    res_q      <= res_d;
    m_res_q    <= m_res_d;
  end

  a_tick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TICK)
    |=> now_q == $past(now_q) + tm_t'(1))
    else $error("tick did not advance the count");

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CNT_W'(MAX_RES))
    else $error("too many expiries in one tick");

  a_cancel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CANCEL) && in_valid
    |=> !active_q[$past(in_idx)])
    else $error("cancelled slot still active");

  a_idle_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_valid_q)
    else $error("expiry left unreported");

endmodule
